// ===== rtl/rgb_layer_blend_unit_assert.svh =====
// assertion macros shared by the blend unit modules
`ifndef RGB_LAYER_BLEND_UNIT_ASSERT_SVH
`define RGB_LAYER_BLEND_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define RLB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgb_layer_blend_unit assertion failed");

// next-cycle implication, off during reset
`define RLB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgb_layer_blend_unit assertion failed");

`endif

// ===== rtl/rlb_pkg.sv =====
// shared types, mode codes and rounding helpers of the blend unit
package rlb_pkg;

  localparam int ONE = 4096;
  localparam int HALF = 2048;
  localparam logic signed [15:0] HALF16 = 16'sd2048;
  localparam logic signed [23:0] ONE24 = 24'sd4096;
  localparam logic signed [23:0] HALF24 = 24'sd2048;
  localparam logic signed [33:0] ONE34 = 34'sd4096;
  localparam logic signed [33:0] HALF34 = 34'sd2048;

  // divider and square root step counts
  localparam int DIV_STEPS = 31;
  localparam int SQRT_STEPS = 14;
  // input reg + 3 front stages + divider steps + 5 back stages
  localparam int LATENCY = 1 + 3 + DIV_STEPS + 5;

  // blend mode codes
  localparam logic [4:0] MODE_NORMAL       = 5'd0;
  localparam logic [4:0] MODE_LIGHTEN      = 5'd1;
  localparam logic [4:0] MODE_DARKEN       = 5'd2;
  localparam logic [4:0] MODE_MULTIPLY     = 5'd3;
  localparam logic [4:0] MODE_AVERAGE      = 5'd4;
  localparam logic [4:0] MODE_ADD          = 5'd5;
  localparam logic [4:0] MODE_SUBTRACT     = 5'd6;
  localparam logic [4:0] MODE_DIFFERENCE   = 5'd7;
  localparam logic [4:0] MODE_NEGATION     = 5'd8;
  localparam logic [4:0] MODE_EXCLUSION    = 5'd9;
  localparam logic [4:0] MODE_SCREEN       = 5'd10;
  localparam logic [4:0] MODE_OVERLAY      = 5'd11;
  localparam logic [4:0] MODE_SOFT_LIGHT   = 5'd12;
  localparam logic [4:0] MODE_HARD_LIGHT   = 5'd13;
  localparam logic [4:0] MODE_COLOR_DODGE  = 5'd14;
  localparam logic [4:0] MODE_COLOR_BURN   = 5'd15;
  localparam logic [4:0] MODE_LINEAR_DODGE = 5'd16;
  localparam logic [4:0] MODE_LINEAR_BURN  = 5'd17;
  localparam logic [4:0] MODE_LINEAR_LIGHT = 5'd18;
  localparam logic [4:0] MODE_VIVID_LIGHT  = 5'd19;
  localparam logic [4:0] MODE_PIN_LIGHT    = 5'd20;
  localparam logic [4:0] MODE_HARD_MIX     = 5'd21;
  localparam logic [4:0] MODE_REFLECT      = 5'd22;
  localparam logic [4:0] MODE_GLOW         = 5'd23;
  localparam logic [4:0] MODE_PHOENIX      = 5'd24;

  // kind of quotient a mode needs
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_DODGE   = 2'd1;
  localparam logic [1:0] KIND_BURN    = 2'd2;
  localparam logic [1:0] KIND_REFLECT = 2'd3;

  // per-channel data that rides along the divider
  typedef struct packed {
    logic signed [15:0] b;
    logic [12:0]        a;
    logic [4:0]         op;
    logic signed [15:0] r_simple;
    logic [1:0]         kind;
    logic               zero;
    logic               neg;
    logic               sl_lo;
    logic signed [21:0] sl_add;
    logic signed [17:0] sl_m;
    logic signed [19:0] qm_bb;
  } rlb_side_t;

  // divider and square root working state
  typedef struct packed {
    logic [16:0] rem;
    logic [30:0] nq;
    logic [16:0] den;
    logic [15:0] srem;
    logic [13:0] root;
    logic [27:0] sv;
  } rlb_iter_t;

  // round half up from Q.24 products to Q.12
  function automatic logic signed [27:0] rnd12(input logic signed [39:0] x);
    logic signed [39:0] t;
    t = x + 40'sd2048;
    return t[39:12];
  endfunction

  // saturate to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [39:0] x);
    logic signed [15:0] r;
    if (x > 40'sd32767) begin
      r = 16'sh7fff;
    end else if (x < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/rlb_front.sv =====
// operand preparation: products, simple modes, divider and square root setup
module rlb_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clamp,
  input  logic                   in_valid,
  input  logic signed [15:0]     b,
  input  logic signed [15:0]     l,
  input  logic [12:0]            a,
  input  logic [4:0]             op,
  output logic                   out_valid,
  output rlb_pkg::rlb_side_t     out_side,
  output rlb_pkg::rlb_iter_t     out_st
);
  import rlb_pkg::*;

  // stage a registers
  logic               va;
  logic signed [15:0] ba, la;
  logic [12:0]        aa;
  logic [4:0]         opa;
  logic signed [31:0] pbl, pbb, pll;
  logic signed [33:0] pnn;
  logic signed [16:0] nba, nla;
  logic signed [16:0] nb_next, nl_next;

  // stage b registers
  logic               vb;
  logic signed [15:0] bb, lb;
  logic [12:0]        ab;
  logic [4:0]         opb;
  logic signed [21:0] qbl, q2bl, qnn, q2nn, q2b1l;
  logic signed [19:0] qbb;
  logic signed [32:0] numb;
  logic signed [18:0] denb;
  logic [1:0]         kindb;
  logic signed [32:0] num_next;
  logic signed [18:0] den_next;
  logic [1:0]         kind_next;
  logic               vivid;

  // stage c logic
  logic signed [23:0] rw, bw, lw, tw;
  logic signed [32:0] num_abs;
  logic signed [18:0] den_abs;
  rlb_side_t          side_next;
  rlb_iter_t          st_next;

  // stage a: raw products
  always_comb begin
    nb_next = 17'sd4096 - 17'(b);
    nl_next = 17'sd4096 - 17'(l);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_valid;
    end
    ba  <= b;
    la  <= l;
    aa  <= a;
    opa <= op;
    nba <= nb_next;
    nla <= nl_next;
    pbl <= 32'(b) * 32'(l);
    pbb <= 32'(b) * 32'(b);
    pll <= 32'(l) * 32'(l);
    pnn <= 34'(nb_next) * 34'(nl_next);
  end

  // stage b: rounded products and quotient operand selection
  always_comb begin
    vivid     = (opa == MODE_VIVID_LIGHT) || (opa == MODE_HARD_MIX);
    kind_next = KIND_NONE;
    num_next  = '0;
    den_next  = 19'sd1;
    if (opa == MODE_COLOR_DODGE) begin
      kind_next = KIND_DODGE;
      num_next  = 33'(ba) <<< 12;
      den_next  = 19'(nla);
    end else if (vivid && (la >= HALF16)) begin
      kind_next = KIND_DODGE;
      num_next  = 33'(ba) <<< 12;
      den_next  = 19'sd8192 - (19'(la) <<< 1);
    end else if (opa == MODE_COLOR_BURN) begin
      kind_next = KIND_BURN;
      num_next  = 33'(nba) <<< 12;
      den_next  = 19'(la);
    end else if (vivid) begin
      kind_next = KIND_BURN;
      num_next  = 33'(nba) <<< 12;
      den_next  = 19'(la) <<< 1;
    end else if (opa == MODE_REFLECT) begin
      kind_next = KIND_REFLECT;
      num_next  = 33'(pbb);
      den_next  = 19'(nla);
    end else if (opa == MODE_GLOW) begin
      kind_next = KIND_REFLECT;
      num_next  = 33'(pll);
      den_next  = 19'(nba);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    bb    <= ba;
    lb    <= la;
    ab    <= aa;
    opb   <= opa;
    qbl   <= 22'(rnd12(40'(pbl)));
    q2bl  <= 22'(rnd12(40'(pbl) <<< 1));
    qnn   <= 22'(rnd12(40'(pnn)));
    q2nn  <= 22'(rnd12(40'(pnn) <<< 1));
    q2b1l <= 22'(rnd12((40'(ba) <<< 13) - (40'(pbl) <<< 1)));
    qbb   <= 20'(rnd12(40'(pbb)));
    numb  <= num_next;
    denb  <= den_next;
    kindb <= kind_next;
  end

  // stage c: simple modes, magnitudes for the divider, square root radicand
  always_comb begin
    bw = 24'(bb);
    lw = 24'(lb);
    tw = '0;
    rw = lw;
    case (opb) inside
      MODE_LIGHTEN:  rw = (bw > lw) ? bw : lw;
      MODE_DARKEN:   rw = (bw < lw) ? bw : lw;
      MODE_MULTIPLY: rw = 24'(qbl);
      MODE_AVERAGE:  rw = (bw + lw + 24'sd1) >>> 1;
      MODE_ADD, MODE_LINEAR_DODGE: begin
        rw = bw + lw;
        if (clamp && (rw > ONE24)) begin
          rw = ONE24;
        end
      end
      MODE_SUBTRACT, MODE_LINEAR_BURN: begin
        rw = bw + lw - ONE24;
        if (clamp && (rw < 24'sd0)) begin
          rw = '0;
        end
      end
      MODE_DIFFERENCE: begin
        tw = bw - lw;
        rw = (tw < 24'sd0) ? -tw : tw;
      end
      MODE_NEGATION: begin
        tw = ONE24 - bw - lw;
        rw = ONE24 - ((tw < 24'sd0) ? -tw : tw);
      end
      MODE_EXCLUSION:  rw = bw + lw - 24'(q2bl);
      MODE_SCREEN:     rw = ONE24 - 24'(qnn);
      MODE_OVERLAY:    rw = (bw < HALF24) ? 24'(q2bl) : ONE24 - 24'(q2nn);
      MODE_HARD_LIGHT: rw = (lw < HALF24) ? 24'(q2bl) : ONE24 - 24'(q2nn);
      MODE_LINEAR_LIGHT: begin
        rw = bw + (lw <<< 1) - ONE24;
        if (clamp && (rw < 24'sd0)) begin
          rw = '0;
        end else if (clamp && (rw > ONE24)) begin
          rw = ONE24;
        end
      end
      MODE_PIN_LIGHT: begin
        tw = lw <<< 1;
        if (lw < HALF24) begin
          rw = (bw < tw) ? bw : tw;
        end else begin
          rw = (bw > tw - ONE24) ? bw : tw - ONE24;
        end
      end
      MODE_PHOENIX: begin
        rw = ((bw < lw) ? bw : lw) - ((bw > lw) ? bw : lw) + ONE24;
      end
      default: rw = lw;
    endcase

    num_abs = numb[32] ? -numb : numb;
    den_abs = denb[18] ? -denb : denb;

    side_next.b        = bb;
    side_next.a        = ab;
    side_next.op       = opb;
    side_next.r_simple = sat16(40'(rw));
    side_next.kind     = kindb;
    side_next.zero     = (denb == 19'sd0);
    side_next.neg      = numb[32] ^ denb[18];
    side_next.sl_lo    = (lb < HALF16);
    side_next.sl_add   = (lb < HALF16) ? q2bl : q2b1l;
    side_next.sl_m     = (lb < HALF16) ? 18'sd4096 - (18'(lb) <<< 1)
                                       : (18'(lb) <<< 1) - 18'sd4096;
    side_next.qm_bb    = qbb;

    st_next.rem  = '0;
    st_next.nq   = num_abs[30:0];
    st_next.den  = den_abs[16:0];
    st_next.srem = '0;
    st_next.root = '0;
    st_next.sv   = (bb > 16'sd0) ? {1'b0, bb[14:0], 12'b0} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vb;
    end
    out_side <= side_next;
    out_st   <= st_next;
  end

endmodule

// ===== rtl/rlb_iter.sv =====
// one registered step of the restoring divider and the square root
module rlb_iter (
  input  logic               clk,
  input  logic               rst,
  input  logic               sqrt_en,
  input  logic               in_valid,
  input  rlb_pkg::rlb_side_t in_side,
  input  rlb_pkg::rlb_iter_t in_st,
  output logic               out_valid,
  output rlb_pkg::rlb_side_t out_side,
  output rlb_pkg::rlb_iter_t out_st
);
  import rlb_pkg::*;

  logic [17:0] dt, st2, trial;
  logic        dge, sge;
  rlb_iter_t   st_next;

  // one quotient bit and, when sqrt_en is set, one root bit
  always_comb begin
    st_next = in_st;
    dt      = {in_st.rem, in_st.nq[30]};
    dge     = (dt >= {1'b0, in_st.den});
    st_next.rem = dge ? 17'(dt - {1'b0, in_st.den}) : dt[16:0];
    st_next.nq  = {in_st.nq[29:0], dge};

    st2   = {in_st.srem, in_st.sv[27:26]};
    trial = {2'b00, in_st.root, 2'b01};
    sge   = (st2 >= trial);
    if (sqrt_en) begin
      st_next.srem = sge ? 16'(st2 - trial) : st2[15:0];
      st_next.root = {in_st.root[12:0], sge};
      st_next.sv   = {in_st.sv[25:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_side <= in_side;
    out_st   <= st_next;
  end

endmodule

// ===== rtl/rlb_back.sv =====
// quotient fixups, soft light, mode select and opacity interpolation
module rlb_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               clamp,
  input  logic               in_valid,
  input  rlb_pkg::rlb_side_t in_side,
  input  rlb_pkg::rlb_iter_t in_st,
  output logic               out_valid,
  output logic signed [15:0] out_value
);
  import rlb_pkg::*;

  // stage k1
  logic               v1;
  rlb_side_t          s1;
  logic signed [33:0] q1;
  logic signed [37:0] prod1;
  logic signed [19:0] mul_a;

  // stage k2
  logic               v2;
  rlb_side_t          s2;
  logic signed [15:0] rdiv2, rsoft2;
  logic signed [33:0] rd;

  // stage k3
  logic               v3;
  logic signed [15:0] b3;
  logic [12:0]        a3;
  logic signed [16:0] d3;
  logic signed [15:0] r_sel;

  // stage k4
  logic               v4;
  logic signed [15:0] b4;
  logic signed [30:0] pm4;

  logic signed [39:0] acc;

  // k1: signed quotient and soft light product
  always_comb begin
    mul_a = in_side.sl_lo ? in_side.qm_bb : $signed({6'b0, in_st.root});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    s1    <= in_side;
    q1    <= in_side.neg ? -$signed({3'b000, in_st.nq}) : $signed({3'b000, in_st.nq});
    prod1 <= 38'(mul_a) * 38'(in_side.sl_m);
  end

  // k2: divide-by-zero guards, clamps and the hard mix threshold
  always_comb begin
    rd = q1;
    unique case (s1.kind)
      KIND_DODGE: begin
        if (s1.zero || (clamp && (q1 > ONE34))) begin
          rd = ONE34;
        end
      end
      KIND_BURN: begin
        rd = ONE34 - q1;
        if (s1.zero || (rd < 34'sd0)) begin
          rd = '0;
        end
      end
      KIND_REFLECT: begin
        if (s1.zero) begin
          rd = ONE34;
        end else if (clamp && (q1 > ONE34)) begin
          rd = ONE34;
        end else if (clamp && (q1 < 34'sd0)) begin
          rd = '0;
        end
      end
      default: rd = q1;
    endcase
    if (s1.op == MODE_HARD_MIX) begin
      rd = (rd < HALF34) ? 34'sd0 : ONE34;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2     <= s1;
    rdiv2  <= sat16(40'(rd));
    rsoft2 <= sat16(40'(s1.sl_add) + 40'(rnd12(40'(prod1))));
  end

  // k3: pick the mode result, difference from base
  always_comb begin
    if (s2.kind != KIND_NONE) begin
      r_sel = rdiv2;
    end else if (s2.op == MODE_SOFT_LIGHT) begin
      r_sel = rsoft2;
    end else begin
      r_sel = s2.r_simple;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    b3 <= s2.b;
    a3 <= s2.a;
    d3 <= 17'(r_sel) - 17'(s2.b);
  end

  // k4: weight by opacity
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    b4  <= b3;
    pm4 <= 31'(d3) * 31'($signed({1'b0, a3}));
  end

  // k5: add base, round, saturate
  always_comb begin
    acc = (40'(b4) <<< 12) + 40'(pm4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v4;
    end
    out_value <= sat16(40'(rnd12(acc)));
  end

  `include "rgb_layer_blend_unit_assert.svh"

  `RLB_ASSERT_NEXT(a_hard_mix_bin, v1 && s1.op == MODE_HARD_MIX, rdiv2 == '0 || rdiv2 == 16'sd4096)
  `RLB_ASSERT_NEXT(a_dodge_clamped, v1 && clamp && (s1.kind == KIND_DODGE), rdiv2 <= 16'sd4096)

endmodule

// ===== rtl/rlb_channel.sv =====
// one color channel: front, divider/sqrt step chain, back
module rlb_channel (
  input  logic               clk,
  input  logic               rst,
  input  logic               clamp,
  input  logic               in_valid,
  input  logic signed [15:0] b,
  input  logic signed [15:0] l,
  input  logic [12:0]        a,
  input  logic [4:0]         op,
  output logic               out_valid,
  output logic signed [15:0] out_value
);
  import rlb_pkg::*;

  logic      cv [DIV_STEPS+1];
  rlb_side_t cs [DIV_STEPS+1];
  rlb_iter_t ct [DIV_STEPS+1];

  rlb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .clamp     (clamp),
    .in_valid  (in_valid),
    .b         (b),
    .l         (l),
    .a         (a),
    .op        (op),
    .out_valid (cv[0]),
    .out_side  (cs[0]),
    .out_st    (ct[0])
  );

  // one divider step per stage, square root in the first stages
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    rlb_iter u_iter (
      .clk       (clk),
      .rst       (rst),
      .sqrt_en   (k < SQRT_STEPS),
      .in_valid  (cv[k]),
      .in_side   (cs[k]),
      .in_st     (ct[k]),
      .out_valid (cv[k+1]),
      .out_side  (cs[k+1]),
      .out_st    (ct[k+1])
    );
  end

  rlb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .clamp     (clamp),
    .in_valid  (cv[DIV_STEPS]),
    .in_side   (cs[DIV_STEPS]),
    .in_st     (ct[DIV_STEPS]),
    .out_valid (out_valid),
    .out_value (out_value)
  );

endmodule

// ===== rtl/rgb_layer_blend_unit.sv =====
// Per-channel layer blend of an RGB pixel pair, 25 modes, opacity mix, Q3.12.
// A pixel is taken on every clock with start high; busy is low except in reset.
// Each result appears for one cycle with done high, in order; the receiver
// cannot stall, so results must be taken as they come. The latency is set by
// the 31-step restoring divider (one quotient bit per stage) shared by dodge,
// burn, vivid light, hard mix, reflect and glow, plus input register, three
// operand stages and five result stages. The clamp register is written through
// cfg_valid/cfg_ready/cfg_data; the user must write it only while no pixel is
// in flight, as the block itself does not enforce it.
module rgb_layer_blend_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] base_red,
  input  logic signed [15:0] base_green,
  input  logic signed [15:0] base_blue,
  input  logic signed [15:0] layer_red,
  input  logic signed [15:0] layer_green,
  input  logic signed [15:0] layer_blue,
  input  logic [12:0]        opacity,
  input  logic [4:0]         operation,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  output logic               done,
  output logic signed [15:0] out_red,
  output logic signed [15:0] out_green,
  output logic signed [15:0] out_blue
);
  import rlb_pkg::*;

  logic               clamp_enable;
  logic               v0;
  logic signed [15:0] br, bg, bl, lr, lg, lbl;
  logic [12:0]        a0;
  logic [4:0]         op0;
  logic               done_g, done_b;

  assign busy      = rst;
  assign cfg_ready = !rst;

  // clamp register
  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      clamp_enable <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    br  <= base_red;
    bg  <= base_green;
    bl  <= base_blue;
    lr  <= layer_red;
    lg  <= layer_green;
    lbl <= layer_blue;
    a0  <= opacity;
    op0 <= operation;
  end

  // three identical channel pipelines
  rlb_channel u_red (
    .clk (clk), .rst (rst), .clamp (clamp_enable), .in_valid (v0),
    .b (br), .l (lr), .a (a0), .op (op0),
    .out_valid (done), .out_value (out_red)
  );

  rlb_channel u_green (
    .clk (clk), .rst (rst), .clamp (clamp_enable), .in_valid (v0),
    .b (bg), .l (lg), .a (a0), .op (op0),
    .out_valid (done_g), .out_value (out_green)
  );

  rlb_channel u_blue (
    .clk (clk), .rst (rst), .clamp (clamp_enable), .in_valid (v0),
    .b (bl), .l (lbl), .a (a0), .op (op0),
    .out_valid (done_b), .out_value (out_blue)
  );

  `include "rgb_layer_blend_unit_assert.svh"

  `RLB_ASSERT_IMPL(a_result_follows, start && !busy, ##LATENCY done)
  `RLB_ASSERT_IMPL(a_result_has_source, done, $past(start && !busy, LATENCY))
  `RLB_ASSERT_IMPL(a_channels_aligned, done || done_g || done_b, done && done_g && done_b)

endmodule
